// ===== hw/rtl/gbn_pkg.sv =====
package gbn_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);

    localparam int SEQ_W      = 32;
    localparam int CNT_W      = 32;
    localparam int AWIN_W     = 16;
    localparam int IWIN_W     = 5;
    localparam int RETRY_W    = 8;
    localparam int TICK_W     = 16;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SENDING = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;
    localparam logic [1:0] PH_FAILED  = 2'd3;

    localparam logic [1:0] REG_INITIAL_WINDOW = 2'd0;
    localparam logic [1:0] REG_MAX_RETRIES    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd2;

    localparam logic [IWIN_W-1:0]  RST_INITIAL_WINDOW = IWIN_W'(10);
    localparam logic [RETRY_W-1:0] RST_MAX_RETRIES    = RETRY_W'(5);
    localparam logic [TICK_W-1:0]  RST_TIMEOUT_TICKS  = TICK_W'(200);

    localparam logic [0:0] KIND_SEND   = 1'b0;
    localparam logic [0:0] KIND_STATUS = 1'b1;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [AWIN_W-1:0] w);
        logic [WIN_W-1:0] res;
        if (w == '0) begin
            res = WIN_W'(1);
        end else if (w > AWIN_W'(MAX_WINDOW)) begin
            res = WIN_W'(MAX_WINDOW);
        end else begin
            res = w[WIN_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/go_back_n_sender_window_core.sv =====
// an item steps through its window-update states (ACK or TICK states, then LIM_SUM and LIM_MIN),
// whose comparisons share one 33-bit comparator, then emits one result per cycle while i_ready
// does not stall the output: up to MAX_WINDOW send words and a final status word; i_valid is taken
// only in the idle state, so a new item waits until the status word of the last one is registered
// reset: synchronous active-low i_rst_n clears the window state and loads the
// register defaults (initial window 10, max retries 5, timeout 200 ticks)
module go_back_n_sender_window_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbn_pkg::ADDR_W-1:0]    paddr,
    input  logic [gbn_pkg::DATA_W-1:0]    pwdata,
    output logic [gbn_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [gbn_pkg::SEQ_W-1:0]     i_total_packets,
    input  logic [gbn_pkg::SEQ_W-1:0]     i_ack_number,
    input  logic [gbn_pkg::AWIN_W-1:0]    i_ack_window,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic [gbn_pkg::SEQ_W-1:0]     o_send_sequence,
    output logic [1:0]                    o_status,
    output logic [gbn_pkg::CNT_W-1:0]     o_retransmissions,
    output logic                          o_last
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_ACK_CMP    = 4'd1;
    localparam logic [3:0] S_ACK_NTS    = 4'd2;
    localparam logic [3:0] S_ACK_DONE   = 4'd3;
    localparam logic [3:0] S_TICK_CMP   = 4'd4;
    localparam logic [3:0] S_TICK_RETRY = 4'd5;
    localparam logic [3:0] S_LIM_SUM    = 4'd6;
    localparam logic [3:0] S_LIM_MIN    = 4'd7;
    localparam logic [3:0] S_EMIT       = 4'd8;

    localparam int CMP_W = gbn_pkg::SEQ_W + 1;

    // configuration
    logic [gbn_pkg::IWIN_W-1:0]  r_initial_window;
    logic [gbn_pkg::RETRY_W-1:0] r_max_retries;
    logic [gbn_pkg::TICK_W-1:0]  r_timeout_ticks;
    logic                        cfg_wr;
    logic [1:0]                  cfg_idx;

    // window state
    logic [3:0]                  r_state, n_state;
    logic [gbn_pkg::SEQ_W-1:0]   r_base, n_base;
    logic [gbn_pkg::SEQ_W-1:0]   r_nts, n_nts;
    logic [gbn_pkg::WIN_W-1:0]   r_win, n_win;
    logic [gbn_pkg::SEQ_W-1:0]   r_total, n_total;
    logic [gbn_pkg::RETRY_W-1:0] r_retry, n_retry;
    logic [gbn_pkg::TICK_W-1:0]  r_idle, n_idle;
    logic [gbn_pkg::CNT_W-1:0]   r_rewind, n_rewind;
    logic [1:0]                  r_phase, n_phase;
    logic [CMP_W-1:0]            r_bound, n_bound;

    // latched input word
    logic [gbn_pkg::SEQ_W-1:0]   r_ack, n_ack;
    logic [gbn_pkg::AWIN_W-1:0]  r_awin, n_awin;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_kind, n_out_kind;
    logic [gbn_pkg::SEQ_W-1:0]   r_out_seq, n_out_seq;
    logic [1:0]                  r_out_status, n_out_status;
    logic [gbn_pkg::CNT_W-1:0]   r_out_rtx, n_out_rtx;
    logic                        r_out_last, n_out_last;

    // shared compare unit
    logic [CMP_W-1:0]            cmp_a, cmp_b;
    logic                        cmp_lt;
    logic [gbn_pkg::TICK_W:0]    tick_next;
    logic [gbn_pkg::RETRY_W:0]   retry_next;
    logic                        out_free;
    logic                        accept;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            gbn_pkg::REG_INITIAL_WINDOW:
                prdata = gbn_pkg::DATA_W'(r_initial_window);
            gbn_pkg::REG_MAX_RETRIES:
                prdata = gbn_pkg::DATA_W'(r_max_retries);
            gbn_pkg::REG_TIMEOUT_TICKS:
                prdata = gbn_pkg::DATA_W'(r_timeout_ticks);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_window <= gbn_pkg::RST_INITIAL_WINDOW;
            r_max_retries    <= gbn_pkg::RST_MAX_RETRIES;
            r_timeout_ticks  <= gbn_pkg::RST_TIMEOUT_TICKS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                gbn_pkg::REG_INITIAL_WINDOW:
                    r_initial_window <= pwdata[gbn_pkg::IWIN_W-1:0];
                gbn_pkg::REG_MAX_RETRIES:
                    r_max_retries <= pwdata[gbn_pkg::RETRY_W-1:0];
                gbn_pkg::REG_TIMEOUT_TICKS:
                    r_timeout_ticks <= pwdata[gbn_pkg::TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign tick_next  = {1'b0, r_idle} + 1'b1;
    assign retry_next = {1'b0, r_retry} + 1'b1;

    always_comb begin
        case (r_state)
            S_ACK_CMP: begin
                cmp_a = {1'b0, r_base};
                cmp_b = {1'b0, r_ack};
            end
            S_ACK_NTS: begin
                cmp_a = {1'b0, r_nts};
                cmp_b = {1'b0, r_base};
            end
            S_ACK_DONE: begin
                cmp_a = {1'b0, r_base};
                cmp_b = {1'b0, r_total};
            end
            S_TICK_CMP: begin
                cmp_a = CMP_W'(r_timeout_ticks);
                cmp_b = CMP_W'(tick_next);
            end
            S_TICK_RETRY: begin
                cmp_a = CMP_W'(r_max_retries);
                cmp_b = CMP_W'(retry_next);
            end
            S_LIM_MIN: begin
                cmp_a = {1'b0, r_total};
                cmp_b = r_bound;
            end
            S_EMIT: begin
                cmp_a = {1'b0, r_nts};
                cmp_b = r_bound;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt   = cmp_a < cmp_b;
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_nts        = r_nts;
        n_win        = r_win;
        n_total      = r_total;
        n_retry      = r_retry;
        n_idle       = r_idle;
        n_rewind     = r_rewind;
        n_phase      = r_phase;
        n_bound      = r_bound;
        n_ack        = r_ack;
        n_awin       = r_awin;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_kind   = r_out_kind;
        n_out_seq    = r_out_seq;
        n_out_status = r_out_status;
        n_out_rtx    = r_out_rtx;
        n_out_last   = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ack  = i_ack_number;
                    n_awin = i_ack_window;
                    if (i_cmd == gbn_pkg::CMD_START) begin
                        n_total  = i_total_packets;
                        n_base   = '0;
                        n_nts    = '0;
                        n_win    = gbn_pkg::clamp_window(
                                       gbn_pkg::AWIN_W'(r_initial_window));
                        n_retry  = '0;
                        n_idle   = '0;
                        n_rewind = '0;
                        if (i_total_packets == '0) begin
                            n_phase = gbn_pkg::PH_DONE;
                            n_state = S_EMIT;
                        end else begin
                            n_phase = gbn_pkg::PH_SENDING;
                            n_state = S_LIM_SUM;
                        end
                    end else if (r_phase != gbn_pkg::PH_SENDING) begin
                        n_state = S_EMIT;
                    end else if (i_cmd == gbn_pkg::CMD_ACK) begin
                        n_state = S_ACK_CMP;
                    end else if (i_cmd == gbn_pkg::CMD_TICK) begin
                        n_state = S_TICK_CMP;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_ACK_CMP: begin
                if (cmp_lt) begin
                    n_base  = r_ack;
                    n_win   = gbn_pkg::clamp_window(r_awin);
                    n_retry = '0;
                    n_idle  = '0;
                    n_state = S_ACK_NTS;
                end else begin
                    n_state = S_LIM_SUM;
                end
            end
            S_ACK_NTS: begin
                if (cmp_lt) begin
                    n_nts = r_base;
                end
                n_state = S_ACK_DONE;
            end
            S_ACK_DONE: begin
                if (!cmp_lt) begin
                    n_phase = gbn_pkg::PH_DONE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LIM_SUM;
                end
            end
            S_TICK_CMP: begin
                if (cmp_lt) begin
                    n_idle  = '0;
                    n_state = S_TICK_RETRY;
                end else begin
                    n_idle  = tick_next[gbn_pkg::TICK_W] ? '1
                                                         : tick_next[gbn_pkg::TICK_W-1:0];
                    n_state = S_LIM_SUM;
                end
            end
            S_TICK_RETRY: begin
                if (cmp_lt) begin
                    n_retry = retry_next[gbn_pkg::RETRY_W] ? '1
                                                           : retry_next[gbn_pkg::RETRY_W-1:0];
                    n_phase = gbn_pkg::PH_FAILED;
                    n_state = S_EMIT;
                end else begin
                    n_retry = retry_next[gbn_pkg::RETRY_W-1:0];
                    n_nts   = r_base;
                    if (r_rewind != '1) begin
                        n_rewind = r_rewind + 1'b1;
                    end
                    n_state = S_LIM_SUM;
                end
            end
            S_LIM_SUM: begin
                n_bound = {1'b0, r_base} + CMP_W'(r_win);
                n_state = S_LIM_MIN;
            end
            S_LIM_MIN: begin
                if (cmp_lt) begin
                    n_bound = {1'b0, r_total};
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_phase;
                    n_out_rtx    = r_rewind;
                    if (r_phase == gbn_pkg::PH_SENDING && cmp_lt) begin
                        n_out_kind = gbn_pkg::KIND_SEND;
                        n_out_seq  = r_nts;
                        n_out_last = 1'b0;
                        n_nts      = r_nts + 1'b1;
                    end else begin
                        n_out_kind = gbn_pkg::KIND_STATUS;
                        n_out_seq  = r_base;
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_nts       <= '0;
            r_win       <= gbn_pkg::WIN_W'(gbn_pkg::RST_INITIAL_WINDOW);
            r_total     <= '0;
            r_retry     <= '0;
            r_idle      <= '0;
            r_rewind    <= '0;
            r_phase     <= gbn_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_nts       <= n_nts;
            r_win       <= n_win;
            r_total     <= n_total;
            r_retry     <= n_retry;
            r_idle      <= n_idle;
            r_rewind    <= n_rewind;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound      <= n_bound;
        r_ack        <= n_ack;
        r_awin       <= n_awin;
        r_out_kind   <= n_out_kind;
        r_out_seq    <= n_out_seq;
        r_out_status <= n_out_status;
        r_out_rtx    <= n_out_rtx;
        r_out_last   <= n_out_last;
    end

    assign o_valid           = r_out_valid;
    assign o_kind            = r_out_kind;
    assign o_send_sequence   = r_out_seq;
    assign o_status          = r_out_status;
    assign o_retransmissions = r_out_rtx;
    assign o_last            = r_out_last;

endmodule

// ===== tb/sv/go_back_n_sender_window_core_tb.sv =====
module go_back_n_sender_window_core_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned QUIET_LIMIT = 2000;

    typedef struct packed {
        logic                        kind;
        logic [gbn_pkg::SEQ_W-1:0]   seq;
        logic [1:0]                  status;
        logic [gbn_pkg::CNT_W-1:0]   retx;
        logic                        last;
    } t_gbn_word;

    class t_send_window_tracker;
        logic [gbn_pkg::IWIN_W-1:0]  cfg_init_win = gbn_pkg::RST_INITIAL_WINDOW;
        logic [gbn_pkg::RETRY_W-1:0] cfg_max_retries = gbn_pkg::RST_MAX_RETRIES;
        logic [gbn_pkg::TICK_W-1:0]  cfg_timeout = gbn_pkg::RST_TIMEOUT_TICKS;

        logic [gbn_pkg::SEQ_W-1:0]   base = '0;
        logic [gbn_pkg::SEQ_W-1:0]   next_seq = '0;
        logic [gbn_pkg::WIN_W-1:0]   win = gbn_pkg::WIN_W'(gbn_pkg::RST_INITIAL_WINDOW);
        logic [gbn_pkg::SEQ_W-1:0]   total = '0;
        logic [gbn_pkg::RETRY_W-1:0] retries = '0;
        logic [gbn_pkg::TICK_W-1:0]  idle = '0;
        logic [gbn_pkg::CNT_W-1:0]   rewinds = '0;
        logic [1:0]                  xfer_phase = gbn_pkg::PH_IDLE;

        t_gbn_word owed_words[$];
        int unsigned errors = 0;
        int unsigned n_items = 0;
        int unsigned n_words = 0;
        int unsigned n_rewinds = 0;
        int unsigned n_done = 0;
        int unsigned n_failed = 0;

        function logic [gbn_pkg::WIN_W-1:0] fit_window(logic [gbn_pkg::AWIN_W-1:0] w);
            if (w == '0) return gbn_pkg::WIN_W'(1);
            if (w > gbn_pkg::AWIN_W'(gbn_pkg::MAX_WINDOW))
                return gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW);
            return w[gbn_pkg::WIN_W-1:0];
        endfunction

        function void set_reg(logic [1:0] idx, logic [gbn_pkg::DATA_W-1:0] val);
            case (idx)
                gbn_pkg::REG_INITIAL_WINDOW: cfg_init_win = val[gbn_pkg::IWIN_W-1:0];
                gbn_pkg::REG_MAX_RETRIES:    cfg_max_retries = val[gbn_pkg::RETRY_W-1:0];
                gbn_pkg::REG_TIMEOUT_TICKS:  cfg_timeout = val[gbn_pkg::TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_item(logic [1:0] cmd, logic [gbn_pkg::SEQ_W-1:0] tot,
                                logic [gbn_pkg::SEQ_W-1:0] ack,
                                logic [gbn_pkg::AWIN_W-1:0] awin);
            logic [gbn_pkg::SEQ_W:0]     limit;
            logic [gbn_pkg::TICK_W:0]    tick_sum;
            logic [gbn_pkg::RETRY_W:0]   retry_next;
            t_gbn_word                   w;
            n_items++;
            case (cmd)
                gbn_pkg::CMD_START: begin
                    total = tot;
                    base = '0;
                    next_seq = '0;
                    win = fit_window(gbn_pkg::AWIN_W'(cfg_init_win));
                    retries = '0;
                    idle = '0;
                    rewinds = '0;
                    xfer_phase = (tot == '0) ? gbn_pkg::PH_DONE : gbn_pkg::PH_SENDING;
                end
                gbn_pkg::CMD_ACK: begin
                    if (xfer_phase == gbn_pkg::PH_SENDING && ack > base) begin
                        base = ack;
                        win = fit_window(awin);
                        retries = '0;
                        idle = '0;
                        if (next_seq < base) next_seq = base;
                        if (base >= total) begin
                            xfer_phase = gbn_pkg::PH_DONE;
                            n_done++;
                        end
                    end
                end
                gbn_pkg::CMD_TICK: begin
                    if (xfer_phase == gbn_pkg::PH_SENDING) begin
                        tick_sum = {1'b0, idle} + 1'b1;
                        if (tick_sum > {1'b0, cfg_timeout}) begin
                            retry_next = {1'b0, retries} + 1'b1;
                            idle = '0;
                            if (retry_next > {1'b0, cfg_max_retries}) begin
                                retries = retry_next[gbn_pkg::RETRY_W]
                                              ? '1 : retry_next[gbn_pkg::RETRY_W-1:0];
                                xfer_phase = gbn_pkg::PH_FAILED;
                                n_failed++;
                            end else begin
                                retries = retry_next[gbn_pkg::RETRY_W-1:0];
                                next_seq = base;
                                if (rewinds != '1) rewinds++;
                                n_rewinds++;
                            end
                        end else begin
                            idle = tick_sum[gbn_pkg::TICK_W]
                                       ? '1 : tick_sum[gbn_pkg::TICK_W-1:0];
                        end
                    end
                end
                default: ;
            endcase

            if (xfer_phase == gbn_pkg::PH_SENDING) begin
                limit = {1'b0, base} + (gbn_pkg::SEQ_W + 1)'(win);
                while ({1'b0, next_seq} < limit && next_seq < total) begin
                    w = '{gbn_pkg::KIND_SEND, next_seq, xfer_phase, rewinds, 1'b0};
                    owed_words.push_back(w);
                    next_seq++;
                end
            end
            w = '{gbn_pkg::KIND_STATUS, base, xfer_phase, rewinds, 1'b1};
            owed_words.push_back(w);
        endfunction

        function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t mismatch %s: expected %0h actual %0h", $time, fname, want, got);
            end
        endfunction

        function void match_word(logic kind, logic [gbn_pkg::SEQ_W-1:0] seq, logic [1:0] st,
                                 logic [gbn_pkg::CNT_W-1:0] retx, logic last);
            t_gbn_word w;
            n_words++;
            if (owed_words.size() == 0) begin
                errors++;
                $display("%0t unexpected word: kind %0h seq %0h status %0h retx %0h last %0h",
                         $time, kind, seq, st, retx, last);
                return;
            end
            w = owed_words.pop_front();
            cmp_field("kind", 32'(w.kind), 32'(kind));
            cmp_field("send_sequence", w.seq, seq);
            cmp_field("status", 32'(w.status), 32'(st));
            cmp_field("retransmissions", w.retx, retx);
            cmp_field("last", 32'(w.last), 32'(last));
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [gbn_pkg::ADDR_W-1:0]    paddr = '0;
    logic [gbn_pkg::DATA_W-1:0]    pwdata = '0;
    logic [gbn_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [1:0]                    i_cmd = gbn_pkg::CMD_START;
    logic [gbn_pkg::SEQ_W-1:0]     i_total_packets = '0;
    logic [gbn_pkg::SEQ_W-1:0]     i_ack_number = '0;
    logic [gbn_pkg::AWIN_W-1:0]    i_ack_window = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic                          o_kind;
    logic [gbn_pkg::SEQ_W-1:0]     o_send_sequence;
    logic [1:0]                    o_status;
    logic [gbn_pkg::CNT_W-1:0]     o_retransmissions;
    logic                          o_last;

    t_send_window_tracker tracker;
    int unsigned          rdy_hold = 0;
    int unsigned          gap_free_left = 0;
    int unsigned          quiet_cycles = 0;

    go_back_n_sender_window_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_total_packets   (i_total_packets),
        .i_ack_number      (i_ack_number),
        .i_ack_window      (i_ack_window),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_send_sequence   (o_send_sequence),
        .o_status          (o_status),
        .o_retransmissions (o_retransmissions),
        .o_last            (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver back-pressure: free-running stretches, short and long stalls
    always @(negedge i_clk) begin
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    i_ready <= 1'b1;
                    rdy_hold <= $urandom_range(30, 120);
                end
                1: begin
                    i_ready <= 1'b0;
                    rdy_hold <= $urandom_range(8, 40);
                end
                2, 3, 4: begin
                    i_ready <= 1'b0;
                    rdy_hold <= $urandom_range(0, 2);
                end
                default: begin
                    i_ready <= 1'b1;
                    rdy_hold <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.match_word(o_kind, o_send_sequence, o_status, o_retransmissions, o_last);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned sender_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gap_free_left != 0) begin
            gap_free_left--;
            return 0;
        end
        if (r < 5) begin
            gap_free_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_word(input logic [1:0] cmd, input logic [gbn_pkg::SEQ_W-1:0] tot,
                             input logic [gbn_pkg::SEQ_W-1:0] ack,
                             input logic [gbn_pkg::AWIN_W-1:0] awin);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_total_packets <= tot;
        i_ack_number <= ack;
        i_ack_window <= awin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.take_item(cmd, tot, ack, awin);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.owed_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [gbn_pkg::DATA_W-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= gbn_pkg::ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int unsigned iw, input int unsigned mr, input int unsigned to);
        drain_results();
        write_reg(gbn_pkg::REG_INITIAL_WINDOW, gbn_pkg::DATA_W'(iw));
        write_reg(gbn_pkg::REG_MAX_RETRIES, gbn_pkg::DATA_W'(mr));
        write_reg(gbn_pkg::REG_TIMEOUT_TICKS, gbn_pkg::DATA_W'(to));
    endtask

    task automatic push_random(output bit counted);
        logic [1:0]                    cmd;
        logic [gbn_pkg::SEQ_W-1:0]     tot;
        logic [gbn_pkg::SEQ_W-1:0]     ack;
        logic [gbn_pkg::AWIN_W-1:0]    awin;
        int unsigned                   r;
        r = $urandom_range(0, 99);
        if (tracker.xfer_phase != gbn_pkg::PH_SENDING) begin
            if (r < 85) cmd = gbn_pkg::CMD_START;
            else if (r < 92) cmd = gbn_pkg::CMD_ACK;
            else if (r < 97) cmd = gbn_pkg::CMD_TICK;
            else cmd = CMD_UNUSED;
        end else begin
            if (r < 6) cmd = gbn_pkg::CMD_START;
            else if (r < 8) cmd = CMD_UNUSED;
            else if (r < 45) cmd = gbn_pkg::CMD_ACK;
            else cmd = gbn_pkg::CMD_TICK;
        end
        counted = (cmd == gbn_pkg::CMD_START) ||
                  (tracker.xfer_phase == gbn_pkg::PH_SENDING && cmd != CMD_UNUSED);

        case ($urandom_range(0, 9))
            0: tot = '0;
            1: tot = $urandom;
            2: tot = $urandom_range(41, 300);
            default: tot = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 9))
            0: ack = (tracker.base >= 3)
                         ? tracker.base - gbn_pkg::SEQ_W'($urandom_range(0, 3))
                         : tracker.base;
            1: ack = $urandom;
            2: ack = tracker.total;
            default: ack = tracker.base
                           + gbn_pkg::SEQ_W'($urandom_range(1, 32'(tracker.win) + 2));
        endcase
        r = $urandom_range(0, 9);
        if (r < 7) awin = gbn_pkg::AWIN_W'($urandom_range(1, gbn_pkg::MAX_WINDOW));
        else if (r < 8) awin = '0;
        else awin = gbn_pkg::AWIN_W'($urandom);
        push_word(cmd, tot, ack, awin);
    endtask

    initial begin
        int unsigned n;
        int unsigned storm;
        bit          counted;

        tracker = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values: window 10, 5 retries, 200 ticks
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'd5, 16'd4);
        push_word(gbn_pkg::CMD_TICK, 32'd0, 32'd0, 16'd0);
        push_word(CMD_UNUSED, 32'd7, 32'd3, 16'd2);
        push_word(gbn_pkg::CMD_START, 32'd0, 32'd0, 16'd0);
        push_word(gbn_pkg::CMD_TICK, 32'd0, 32'd0, 16'd0);
        push_word(gbn_pkg::CMD_START, 32'd20, 32'd0, 16'd0);
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'd0, 16'd8);
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'd3, 16'd0);
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'd12, 16'hFFFF);
        push_word(CMD_UNUSED, 32'd0, 32'd15, 16'd3);
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'd20, 16'd16);
        push_word(gbn_pkg::CMD_START, 32'hFFFF_FFFF, 32'd0, 16'd0);
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'hFFFF_FFF0, 16'd16);
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'hFFFF_FFFF, 16'd1);
        push_word(gbn_pkg::CMD_START, 32'd5, 32'd0, 16'd0);
        push_word(gbn_pkg::CMD_START, 32'd8, 32'd0, 16'd0);
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'd100, 16'd3);

        // timeout, rewind and failure
        configure(16, 1, 1);
        push_word(gbn_pkg::CMD_START, 32'd4, 32'd0, 16'd0);
        repeat (5) push_word(gbn_pkg::CMD_TICK, 32'd0, 32'd0, 16'd0);
        push_word(gbn_pkg::CMD_ACK, 32'd0, 32'd2, 16'd2);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: configure(1, 0, 1);
                1: configure(16, 255, 65535);
                3: configure($urandom_range(1, 16), $urandom_range(0, 255),
                             $urandom_range(1, 20));
                default: configure($urandom_range(1, 16), $urandom_range(0, 4),
                                   $urandom_range(1, 8));
            endcase
            n = 0;
            while (n < 25) begin
                push_random(counted);
                if (counted) n++;
                if (p == 2 && n == 20 && counted) drain_results();
            end
        end

        // repeated timeouts rewind the window until the transfer fails
        configure(1, 16, 1);
        push_word(gbn_pkg::CMD_START, 32'd3, 32'd0, 16'd0);
        storm = 0;
        while (tracker.xfer_phase == gbn_pkg::PH_SENDING && storm < 100) begin
            push_word(gbn_pkg::CMD_TICK, $urandom, $urandom, 16'($urandom));
            storm++;
        end

        drain_results();
        repeat (40) @(posedge i_clk);

        $display("run: %0d input words, %0d result words checked",
                 tracker.n_items, tracker.n_words);
        $display("run: %0d rewinds, %0d transfers acked to the end, %0d failed",
                 tracker.n_rewinds, tracker.n_done, tracker.n_failed);
        if (tracker.errors == 0 && tracker.owed_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
